FILE: sv/bordered_rectangle_pixel_painter_core_defines.svh
// Assertion macros shared by the bordered rectangle painter RTL.
`ifndef BORDERED_RECTANGLE_PIXEL_PAINTER_CORE_DEFINES_SVH
`define BORDERED_RECTANGLE_PIXEL_PAINTER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define BRPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define BRPP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: sv/brpp_pkg.sv
// Types, constants and helper functions for the bordered rectangle painter.
`default_nettype none

package brpp_pkg;

  localparam int DimW    = 13;
  localparam int CoordW  = 12;
  localparam int ChanW   = 8;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int BorderW = 10;
  localparam int PosW    = 18;

  typedef logic signed [PosW-1:0] pos_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CANVAS_WIDTH  = 3'd0,
    CFG_CANVAS_HEIGHT = 3'd1,
    CFG_FIRST_CORNER  = 3'd2,
    CFG_SECOND_CORNER = 3'd3,
    CFG_BORDER_SIZE   = 3'd4,
    CFG_INNER_COLOR   = 3'd5,
    CFG_OUTER_COLOR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] a;
  } rgba_t;

  // Grown and clipped rectangle, plus the inner edges of the border band.
  typedef struct packed {
    logic off;
    pos_t minx;
    pos_t maxx;
    pos_t miny;
    pos_t maxy;
    pos_t bminx;
    pos_t bmaxx;
    pos_t bminy;
    pos_t bmaxy;
  } rect_t;

  function automatic pos_t clamp_pos(pos_t v, pos_t lim);
    pos_t r;
    if (v < 0) begin
      r = '0;
    end else if (v >= lim) begin
      r = lim - pos_t'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // color + floor(p / 255), saturated; p / 255 as (p + 1 + (p >> 8)) >> 8
  function automatic logic [ChanW-1:0] blend_chan(logic [ChanW-1:0] c, logic [15:0] p);
    logic [16:0] t;
    logic [8:0]  q;
    logic [9:0]  s;
    t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    q = t[16:8];
    s = {2'b0, c} + {1'b0, q};
    return (s > 10'd255) ? 8'hFF : s[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/brpp_rect.sv
// Configuration registers and registered rectangle bounds.
`default_nettype none

module brpp_rect import brpp_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output rect_t                   rect_o,
  output rgba_t                   inner_o,
  output rgba_t                   outer_o
);

`include "bordered_rectangle_pixel_painter_core_defines.svh"

  localparam pos_t MaxDimP = pos_t'(MAX_DIM);

  logic [DimW-1:0]    width_q, height_q;
  logic [CfgW-1:0]    corner_a_q, corner_b_q;
  logic [BorderW-1:0] border_q;
  rgba_t              inner_q, outer_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 13'd4096;
      height_q   <= 13'd4096;
      corner_a_q <= '0;
      corner_b_q <= '0;
      border_q   <= '0;
      inner_q    <= '0;
      outer_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CANVAS_WIDTH:  width_q    <= cfg_data_i[DimW-1:0];
        CFG_CANVAS_HEIGHT: height_q   <= cfg_data_i[DimW-1:0];
        CFG_FIRST_CORNER:  corner_a_q <= cfg_data_i;
        CFG_SECOND_CORNER: corner_b_q <= cfg_data_i;
        CFG_BORDER_SIZE:   border_q   <= cfg_data_i[BorderW-1:0];
        CFG_INNER_COLOR:   inner_q    <= rgba_t'(cfg_data_i);
        CFG_OUTER_COLOR:   outer_q    <= rgba_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign inner_o = inner_q;
  assign outer_o = outer_q;

  pos_t  w_raw, h_raw, w_fix, h_fix;
  pos_t  x1, y1, x2, y2, ax, ay, bx, by;
  pos_t  lox, hix, loy, hiy, bs, g;
  pos_t  minx, maxx, miny, maxy;
  rect_t rect_d, rect_q;

  always_comb begin
    w_raw = {5'd0, width_q};
    h_raw = {5'd0, height_q};
    w_fix = (w_raw == '0) ? pos_t'(1) : ((w_raw > MaxDimP) ? MaxDimP : w_raw);
    h_fix = (h_raw == '0) ? pos_t'(1) : ((h_raw > MaxDimP) ? MaxDimP : h_raw);

    x1 = pos_t'($signed(corner_a_q[31:16]));
    y1 = pos_t'($signed(corner_a_q[15:0]));
    x2 = pos_t'($signed(corner_b_q[31:16]));
    y2 = pos_t'($signed(corner_b_q[15:0]));

    bs = {8'd0, border_q};
    g  = (bs + pos_t'(1)) >>> 1;

    ax = clamp_pos(x1, w_fix);
    ay = clamp_pos(y1, h_fix);
    bx = clamp_pos(x2, w_fix);
    by = clamp_pos(y2, h_fix);
    lox = (ax < bx) ? ax : bx;
    hix = (ax < bx) ? bx : ax;
    loy = (ay < by) ? ay : by;
    hiy = (ay < by) ? by : ay;

    // canvas y runs upward, memory rows downward
    minx = lox - g;
    if (minx < 0) minx = '0;
    miny = h_fix - hiy - g;
    if (miny < 0) miny = '0;
    maxx = hix + g;
    if (maxx > w_fix) maxx = w_fix;
    maxy = h_fix - loy + g;
    if (maxy > h_fix) maxy = h_fix;

    rect_d.off   = (x1 < 0 && x2 < 0) || (x1 >= w_fix && x2 >= w_fix) ||
                   (y1 < 0 && y2 < 0) || (y1 >= h_fix && y2 >= h_fix);
    rect_d.minx  = minx;
    rect_d.maxx  = maxx;
    rect_d.miny  = miny;
    rect_d.maxy  = maxy;
    rect_d.bminx = minx + bs;
    rect_d.bminy = miny + bs;
    rect_d.bmaxx = maxx - bs - pos_t'(1);
    rect_d.bmaxy = maxy - bs - pos_t'(1);
  end

  // bounds follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign rect_o = rect_q;

  `BRPP_ASSERT(a_cols_ordered, rect_q.minx <= rect_q.maxx, "column bounds out of order")
  `BRPP_ASSERT(a_rows_ordered, rect_q.miny <= rect_q.maxy, "row bounds out of order")
  `BRPP_ASSERT(a_cols_clipped, rect_q.maxx <= $past(w_fix), "right edge beyond canvas")

endmodule

`default_nettype wire

FILE: sv/brpp_shade.sv
// Pixel datapath: input register, inside/border test and blend, result register.
`default_nettype none

module brpp_shade import brpp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [CoordW-1:0] pixel_col_i,
  input  wire logic [CoordW-1:0] pixel_row_i,
  input  wire rgba_t             dst_i,
  input  wire rect_t             rect_i,
  input  wire rgba_t             inner_i,
  input  wire rgba_t             outer_i,
  output logic                   done_o,
  output rgba_t                  res_o,
  output logic                   painted_o,
  output logic                   on_border_o
);

`include "bordered_rectangle_pixel_painter_core_defines.svh"

  logic              vld_q, done_q;
  logic [CoordW-1:0] col_q, row_q;
  rgba_t             dst_q, res_d, res_q;
  logic              painted_d, painted_q, on_border_d, on_border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= take_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
      dst_q <= dst_i;
    end
  end

  pos_t        col, row;
  rgba_t       c;
  logic [15:0] prod_r, prod_g, prod_b;
  logic [8:0]  sum_a;

  always_comb begin
    col = {6'd0, col_q};
    row = {6'd0, row_q};
    painted_d = !rect_i.off &&
                col >= rect_i.minx && col < rect_i.maxx &&
                row >= rect_i.miny && row < rect_i.maxy;
    on_border_d = painted_d &&
                  (col < rect_i.bminx || row < rect_i.bminy ||
                   col > rect_i.bmaxx || row > rect_i.bmaxy);
    c = on_border_d ? outer_i : inner_i;

    prod_r = {8'd0, dst_q.r} * {8'd0, dst_q.a};
    prod_g = {8'd0, dst_q.g} * {8'd0, dst_q.a};
    prod_b = {8'd0, dst_q.b} * {8'd0, dst_q.a};
    sum_a  = {1'b0, c.a} + {1'b0, dst_q.a};

    if (painted_d) begin
      res_d.r = blend_chan(c.r, prod_r);
      res_d.g = blend_chan(c.g, prod_g);
      res_d.b = blend_chan(c.b, prod_b);
      res_d.a = sum_a[8] ? 8'hFF : sum_a[7:0];
    end else begin
      res_d = dst_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q       <= res_d;
      painted_q   <= painted_d;
      on_border_q <= on_border_d;
    end
  end

  assign done_o      = done_q;
  assign res_o       = res_q;
  assign painted_o   = painted_q;
  assign on_border_o = on_border_q;

  `BRPP_ASSERT_ALWAYS(a_border_is_painted, done_q && on_border_q |-> painted_q,
                      "border flagged on an unpainted pixel")
  `BRPP_ASSERT(a_unpainted_keeps_pixel, done_q && !painted_q |-> res_q == $past(dst_q),
               "unpainted pixel changed")
  `BRPP_ASSERT(a_alpha_never_drops, done_q && painted_q |-> res_q.a >= $past(dst_q.a),
               "painted alpha below destination alpha")

endmodule

`default_nettype wire

FILE: sv/bordered_rectangle_pixel_painter_core.sv
// Top level of the bordered rectangle pixel painter.
//
// Pixel channel: a transaction is taken at each rising edge with start_i high
// and busy_o low; busy_o is always low, so one pixel may enter every cycle.
// Each pixel gives one result once it has passed the input register and the
// result register: done_o is high for exactly one cycle with new_*_o,
// painted_o and on_border_o valid. The receiver cannot stall; results leave
// at the input rate, one per cycle. Between the two registers sits the
// test-and-blend logic (one 8x8 multiply per color channel).
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Writes land in the configuration registers and
// the rectangle bounds derived from them are registered in the next cycle, so
// a pixel may be started in the cycle after the last write.
// Reset (rst_ni low, asynchronous) sets a 4096 x 4096 canvas, zero corners,
// zero border and black colors, and drops any pixel in flight.
`default_nettype none

module bordered_rectangle_pixel_painter_core import brpp_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [CoordW-1:0]  pixel_col_i,
  input  wire logic [CoordW-1:0]  pixel_row_i,
  input  wire logic [ChanW-1:0]   dst_red_i,
  input  wire logic [ChanW-1:0]   dst_green_i,
  input  wire logic [ChanW-1:0]   dst_blue_i,
  input  wire logic [ChanW-1:0]   dst_alpha_i,
  output logic                    done_o,
  output logic [ChanW-1:0]        new_red_o,
  output logic [ChanW-1:0]        new_green_o,
  output logic [ChanW-1:0]        new_blue_o,
  output logic [ChanW-1:0]        new_alpha_o,
  output logic                    painted_o,
  output logic                    on_border_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  rect_t rect;
  rgba_t inner, outer, dst, res;
  logic  take;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;
  assign dst    = '{r: dst_red_i, g: dst_green_i, b: dst_blue_i, a: dst_alpha_i};

  brpp_rect #(
    .MAX_DIM(MAX_DIM)
  ) u_rect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rect_o      (rect),
    .inner_o     (inner),
    .outer_o     (outer)
  );

  brpp_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .dst_i       (dst),
    .rect_i      (rect),
    .inner_i     (inner),
    .outer_i     (outer),
    .done_o      (done_o),
    .res_o       (res),
    .painted_o   (painted_o),
    .on_border_o (on_border_o)
  );

  assign new_red_o   = res.r;
  assign new_green_o = res.g;
  assign new_blue_o  = res.b;
  assign new_alpha_o = res.a;

endmodule

`default_nettype wire
